// ----- hw/rtl/wsdf_pkg.sv -----
// shared types and constants for the websocket frame deframer
package wsdf_pkg;

    localparam int LENGTH_BITS_DEF = 64;

    // 7-bit length codes that announce an extended length field
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'ha;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_EMPTY     = 3'd1,
        KIND_PONG      = 3'd2,
        KIND_CLOSE     = 3'd3,
        KIND_RSV_ERR   = 3'd4,
        KIND_FRAGMENT  = 3'd5,
        KIND_ILLEGAL   = 3'd6
    } kind_t;

endpackage

// ----- hw/rtl/websocket_frame_deframer_unit.sv -----
// websocket receive deframer: header parse, extended length, mask key, payload unmask
// the output register shows a beat's result in the cycle after its byte is accepted
// throughput: one byte per cycle while out_stall is low, set by the single parse stage
// and output register; the parse stage takes a new byte while a held result is taken
// reset: asynchronous, returns to expecting a first header byte with length, key and
// position cleared; after close or a header error the block drops all bytes until reset
module websocket_frame_deframer_unit #(
    parameter int LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] payload_byte,
    output logic       last_byte
);

    wsdf_pkg::phase_t phase_reg, phase_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             pos_reg, pos_next;
    logic [3:0]             op_reg, op_next;
    logic                   masked_reg, masked_next;

    logic                   out_valid_reg;
    wsdf_pkg::kind_t        kind_reg;
    logic [7:0]             byte_reg;
    logic                   last_reg;

    logic                   in_fire;
    logic                   out_free;
    logic [6:0]             code;
    logic                   code_ext;
    logic [3:0]             cnt_dec;
    logic [LENGTH_BITS-1:0] len_dec;
    logic [LENGTH_BITS-1:0] ext_len;
    logic [7:0]             key_byte;
    logic                   op_data;
    logic                   op_pong;
    logic                   op_halts;
    wsdf_pkg::phase_t       fin_phase;
    wsdf_pkg::kind_t        fin_kind;

    logic                   res_valid;
    wsdf_pkg::kind_t        res_kind;
    logic [7:0]             res_byte;
    logic                   res_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !out_free;
    assign in_fire  = in_valid && out_free;

    assign code     = data_byte[6:0];
    assign code_ext = (code == wsdf_pkg::LEN_CODE_16) || (code == wsdf_pkg::LEN_CODE_64);
    assign cnt_dec  = cnt_reg - 4'd1;
    assign len_dec  = len_reg - LENGTH_BITS'(1);
    // saturate once the length would overflow its register
    assign ext_len  = (|len_reg[LENGTH_BITS-1 -: 8]) ? '1 :
                      {len_reg[LENGTH_BITS-9:0], data_byte};
    assign key_byte = key_reg[{~pos_reg, 3'b000} +: 8];

    assign op_data  = (op_reg == wsdf_pkg::OP_CONT) || (op_reg == wsdf_pkg::OP_TEXT) ||
                      (op_reg == wsdf_pkg::OP_BIN);
    assign op_pong  = (op_reg == wsdf_pkg::OP_PONG);
    assign op_halts = !op_data && !op_pong && (op_reg != wsdf_pkg::OP_PING);

    // end of frame: close and unknown opcodes stop the parser
    assign fin_phase = op_halts ? wsdf_pkg::PH_HALT : wsdf_pkg::PH_HDR0;

    always_comb
    begin
        if (op_data)
            fin_kind = wsdf_pkg::KIND_EMPTY;
        else if (op_reg == wsdf_pkg::OP_CLOSE)
            fin_kind = wsdf_pkg::KIND_CLOSE;
        else if (op_reg == wsdf_pkg::OP_PING)
            fin_kind = wsdf_pkg::KIND_PONG;
        else
            fin_kind = wsdf_pkg::KIND_ILLEGAL;
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        op_next     = op_reg;
        masked_next = masked_reg;
        if (in_fire)
        begin
            case (phase_reg)
                wsdf_pkg::PH_HDR0:
                begin
                    if ((data_byte[6:4] != 3'd0) || !data_byte[7])
                        phase_next = wsdf_pkg::PH_HALT;
                    else
                    begin
                        op_next    = data_byte[3:0];
                        phase_next = wsdf_pkg::PH_HDR1;
                    end
                end
                wsdf_pkg::PH_HDR1:
                begin
                    masked_next = data_byte[7];
                    pos_next    = 2'd0;
                    if (code_ext)
                    begin
                        len_next   = '0;
                        cnt_next   = (code == wsdf_pkg::LEN_CODE_16) ?
                                     wsdf_pkg::EXT_BYTES_16 : wsdf_pkg::EXT_BYTES_64;
                        phase_next = wsdf_pkg::PH_EXTLEN;
                    end
                    else
                    begin
                        len_next = LENGTH_BITS'(code);
                        if (data_byte[7])
                        begin
                            cnt_next   = wsdf_pkg::KEY_BYTES;
                            key_next   = '0;
                            phase_next = wsdf_pkg::PH_KEY;
                        end
                        else if (code == 7'd0)
                            phase_next = fin_phase;
                        else
                            phase_next = wsdf_pkg::PH_PAYLOAD;
                    end
                end
                wsdf_pkg::PH_EXTLEN:
                begin
                    len_next = ext_len;
                    cnt_next = cnt_dec;
                    if (cnt_dec == 4'd0)
                    begin
                        if (masked_reg)
                        begin
                            cnt_next   = wsdf_pkg::KEY_BYTES;
                            key_next   = '0;
                            phase_next = wsdf_pkg::PH_KEY;
                        end
                        else
                        begin
                            pos_next   = 2'd0;
                            phase_next = (ext_len == '0) ? fin_phase : wsdf_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wsdf_pkg::PH_KEY:
                begin
                    key_next = {key_reg[23:0], data_byte};
                    cnt_next = cnt_dec;
                    if (cnt_dec == 4'd0)
                    begin
                        pos_next   = 2'd0;
                        phase_next = (len_reg == '0) ? fin_phase : wsdf_pkg::PH_PAYLOAD;
                    end
                end
                wsdf_pkg::PH_PAYLOAD:
                begin
                    pos_next = pos_reg + 2'd1;
                    len_next = len_dec;
                    if (len_dec == '0)
                        phase_next = fin_phase;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result of the current beat
    always_comb
    begin
        res_valid = 1'b0;
        res_kind  = wsdf_pkg::KIND_PAYLOAD;
        res_byte  = 8'd0;
        res_last  = 1'b0;
        case (phase_reg)
            wsdf_pkg::PH_HDR0:
            begin
                if (data_byte[6:4] != 3'd0)
                begin
                    res_valid = 1'b1;
                    res_kind  = wsdf_pkg::KIND_RSV_ERR;
                end
                else if (!data_byte[7])
                begin
                    res_valid = 1'b1;
                    res_kind  = wsdf_pkg::KIND_FRAGMENT;
                end
            end
            wsdf_pkg::PH_HDR1:
            begin
                if (!code_ext && !data_byte[7] && (code == 7'd0))
                begin
                    res_valid = !op_pong;
                    res_kind  = fin_kind;
                end
            end
            wsdf_pkg::PH_EXTLEN:
            begin
                if ((cnt_dec == 4'd0) && !masked_reg && (ext_len == '0))
                begin
                    res_valid = !op_pong;
                    res_kind  = fin_kind;
                end
            end
            wsdf_pkg::PH_KEY:
            begin
                if ((cnt_dec == 4'd0) && (len_reg == '0))
                begin
                    res_valid = !op_pong;
                    res_kind  = fin_kind;
                end
            end
            wsdf_pkg::PH_PAYLOAD:
            begin
                if (op_data)
                begin
                    res_valid = 1'b1;
                    res_byte  = masked_reg ? (data_byte ^ key_byte) : data_byte;
                    res_last  = (len_dec == '0);
                end
                else if (len_dec == '0)
                begin
                    res_valid = !op_pong;
                    res_kind  = fin_kind;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wsdf_pkg::PH_HDR0;
            cnt_reg       <= 4'd0;
            len_reg       <= '0;
            key_reg       <= '0;
            pos_reg       <= 2'd0;
            op_reg        <= 4'd0;
            masked_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            op_reg     <= op_next;
            masked_reg <= masked_next;
            if (out_free)
                out_valid_reg <= in_fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && out_free)
        begin
            kind_reg <= res_kind;
            byte_reg <= res_byte;
            last_reg <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = byte_reg;
    assign last_byte    = last_reg;

endmodule

// ----- hw/rtl/wsdf_checker.sv -----
// port-level checks for the websocket frame deframer, bound to the top level
module wsdf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] kind,
    input logic [7:0] payload_byte,
    input logic       last_byte
);

    logic halted_reg;
    logic halt_beat;

    // a close or header/opcode error ends all output until reset
    assign halt_beat = out_valid && !out_stall &&
                       ((kind == wsdf_pkg::KIND_CLOSE) || (kind == wsdf_pkg::KIND_RSV_ERR) ||
                        (kind == wsdf_pkg::KIND_FRAGMENT) || (kind == wsdf_pkg::KIND_ILLEGAL));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            halted_reg <= 1'b0;
        else if (halt_beat)
            halted_reg <= 1'b1;
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte))
        else $error("input beat changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte)
            && $stable(last_byte))
        else $error("output beat changed while stalled");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output register");

    a_non_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != wsdf_pkg::KIND_PAYLOAD) |-> (payload_byte == 8'd0) && !last_byte)
        else $error("non-payload result carries payload data");

    a_silent_after_halt: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !out_valid)
        else $error("result given after a halting result");

endmodule

bind websocket_frame_deframer_unit wsdf_checker u_wsdf_checker (.*);
